@@ design/nearest_timestamp_matcher_defines.svh @@
// -----------------------------------------------------------------------------
// Nearest timestamp matcher: assertion macros
// Shared helpers for concurrent checks; all use clk and arst_n of the module.
// -----------------------------------------------------------------------------
`ifndef NEAREST_TIMESTAMP_MATCHER_DEFINES_SVH
`define NEAREST_TIMESTAMP_MATCHER_DEFINES_SVH

// plain property, checked out of reset
`define NTM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define NTM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/ntm_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ntm_pkg
// Types, constants and helpers shared by the nearest timestamp matcher.
// -----------------------------------------------------------------------------
package ntm_pkg;

	localparam int DEPTH = 512;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int KW    = 64;
	localparam int LW    = 41;
	localparam int RW    = 2 * KW;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SCAN    = 7'b0000010,
		ST_SCAN_D1 = 7'b0000100,
		ST_SCAN_D2 = 7'b0001000,
		ST_POP     = 7'b0010000,
		ST_POP_D   = 7'b0100000,
		ST_FINISH  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic record;
		logic lookup;
		logic rd_scan;
		logic rd_pop;
		logic pop_start;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic          empty;
		logic [CW-1:0] count;
	} status_t;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
		logic [AW-1:0] nxt;
		if (ptr == AW'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + AW'(1);
		end
		return nxt;
	endfunction

endpackage

@@ design/ntm_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ntm_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
module ntm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/ntm_dp.sv @@
`timescale 1ns / 1ps
`include "nearest_timestamp_matcher_defines.svh"
// -----------------------------------------------------------------------------
// ntm_dp
// Datapath: pair memory, ring pointers, nearest-distance search, pop compare
// and result register.
// -----------------------------------------------------------------------------
module ntm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ntm_pkg::cmd_t               cmd,
	input  logic signed [ntm_pkg::KW-1:0] source_stamp,
	input  logic signed [ntm_pkg::KW-1:0] host_stamp,
	input  logic signed [ntm_pkg::KW-1:0] current_time,
	input  logic                        cfg_we,
	input  logic signed [ntm_pkg::LW-1:0] latency_ns,
	output ntm_pkg::status_t            status,
	output logic signed [ntm_pkg::KW-1:0] matched_stamp,
	output logic                        was_found
);

	localparam int AW = ntm_pkg::AW;
	localparam int CW = ntm_pkg::CW;
	localparam int KW = ntm_pkg::KW;
	localparam int LW = ntm_pkg::LW;
	localparam int RW = ntm_pkg::RW;

	// ring state
	logic [AW-1:0] head_q, tail_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          full;

	logic [LW-1:0] lat_q;

	// request capture
	logic [KW-1:0] q_src_q, cur_time_q;
	logic          found_q;

	// search pipeline
	logic          first_pend_q;
	logic          scan_v_s1, first_s1, pop_v_s1;
	logic          scan_v_s2, first_s2;
	logic [KW-1:0] d_s2, key_s2, host_s2;
	logic [KW-1:0] best_d_q, best_key_q, best_host_q;
	logic          stop_q;

	logic [RW-1:0] rdata;
	logic [KW-1:0] rd_key, rd_host;
	logic [KW:0]   diff_a, diff_b;
	logic          pop_go;

	logic [KW-1:0] out_stamp_q;
	logic          out_found_q;

	assign full = (count_q == CW'(ntm_pkg::DEPTH));

	ntm_ram #(
		.WIDTH(RW),
		.DEPTH(ntm_pkg::DEPTH)
	) u_pair_ram (
		.clk  (clk),
		.we   (cmd.record),
		.waddr(tail_q),
		.wdata({source_stamp, host_stamp}),
		.re   (cmd.rd_scan | cmd.rd_pop),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	assign rd_key  = rdata[RW-1:KW];
	assign rd_host = rdata[KW-1:0];

	// 65-bit differences both ways; the non-negative one is the distance
	assign diff_a = {rd_key[KW-1], rd_key} - {q_src_q[KW-1], q_src_q};
	assign diff_b = {q_src_q[KW-1], q_src_q} - {rd_key[KW-1], rd_key};

	assign pop_go = pop_v_s1 && !stop_q && ($signed(rd_key) <= $signed(best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			lat_q        <= '0;
			first_pend_q <= 1'b0;
			scan_v_s1    <= 1'b0;
			first_s1     <= 1'b0;
			pop_v_s1     <= 1'b0;
			scan_v_s2    <= 1'b0;
			first_s2     <= 1'b0;
			stop_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				lat_q <= latency_ns;
			end

			if (cmd.record) begin
				tail_q <= ntm_pkg::ptr_inc(tail_q);
				if (full) begin
					head_q <= ntm_pkg::ptr_inc(head_q);
				end else begin
					count_q <= count_q + CW'(1);
				end
			end else if (pop_go) begin
				head_q  <= ntm_pkg::ptr_inc(head_q);
				count_q <= count_q - CW'(1);
			end

			if (cmd.lookup || cmd.pop_start) begin
				rd_ptr_q <= head_q;
			end else if (cmd.rd_scan || cmd.rd_pop) begin
				rd_ptr_q <= ntm_pkg::ptr_inc(rd_ptr_q);
			end

			if (cmd.lookup) begin
				first_pend_q <= 1'b1;
			end else if (cmd.rd_scan) begin
				first_pend_q <= 1'b0;
			end

			scan_v_s1 <= cmd.rd_scan;
			first_s1  <= cmd.rd_scan & first_pend_q;
			pop_v_s1  <= cmd.rd_pop;
			scan_v_s2 <= scan_v_s1;
			first_s2  <= first_s1;

			// popping ends at the first front entry above the best key
			if (cmd.pop_start) begin
				stop_q <= 1'b0;
			end else if (pop_v_s1 && !pop_go) begin
				stop_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			q_src_q    <= source_stamp;
			cur_time_q <= current_time;
			found_q    <= (count_q != '0);
		end
		d_s2    <= diff_a[KW] ? diff_b[KW-1:0] : diff_a[KW-1:0];
		key_s2  <= rd_key;
		host_s2 <= rd_host;
		// strict less keeps the oldest on a tie
		if (scan_v_s2 && (first_s2 || (d_s2 < best_d_q))) begin
			best_d_q    <= d_s2;
			best_key_q  <= key_s2;
			best_host_q <= host_s2;
		end
		if (cmd.load_out) begin
			out_found_q <= found_q;
			out_stamp_q <= found_q ? (best_host_q - {{(KW-LW){lat_q[LW-1]}}, lat_q})
			                       : cur_time_q;
		end
	end

	assign status.empty  = (count_q == '0);
	assign status.count  = count_q;
	assign matched_stamp = out_stamp_q;
	assign was_found     = out_found_q;

	`NTM_ASSERT_IMPL(a_ring_wrap, (count_q == '0) || full, head_q == tail_q, "ring pointers disagree with count")
	`NTM_ASSERT_IMPL(a_pop_nonempty, pop_go, (count_q != '0) && !cmd.record, "pop on empty ring or during record")

endmodule

@@ design/ntm_ctrl.sv @@
`timescale 1ns / 1ps
`include "nearest_timestamp_matcher_defines.svh"
// -----------------------------------------------------------------------------
// ntm_ctrl
// Controller: request acceptance, scan and pop sequencing, result handoff.
// -----------------------------------------------------------------------------
module ntm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              opcode,
	output logic              out_valid,
	input  logic              out_stall,
	input  ntm_pkg::status_t  status,
	output ntm_pkg::cmd_t     cmd
);

	localparam int CW = ntm_pkg::CW;

	ntm_pkg::state_t state_q, state_d;
	logic [CW-1:0]   rem_q, rem_d;
	logic            out_valid_q;

	assign in_stall = (state_q != ntm_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		cmd     = '0;
		unique case (state_q)
			ntm_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (opcode == ntm_pkg::OP_RECORD) begin
						cmd.record = 1'b1;
					end else begin
						cmd.lookup = 1'b1;
						if (status.empty) begin
							state_d = ntm_pkg::ST_FINISH;
						end else begin
							rem_d   = status.count;
							state_d = ntm_pkg::ST_SCAN;
						end
					end
				end
			end
			ntm_pkg::ST_SCAN: begin
				cmd.rd_scan = 1'b1;
				rem_d       = rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					state_d = ntm_pkg::ST_SCAN_D1;
				end
			end
			ntm_pkg::ST_SCAN_D1: begin
				state_d = ntm_pkg::ST_SCAN_D2;
			end
			ntm_pkg::ST_SCAN_D2: begin
				// best entry settles here; re-sweep from the head
				cmd.pop_start = 1'b1;
				rem_d         = status.count;
				state_d       = ntm_pkg::ST_POP;
			end
			ntm_pkg::ST_POP: begin
				cmd.rd_pop = 1'b1;
				rem_d      = rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					state_d = ntm_pkg::ST_POP_D;
				end
			end
			ntm_pkg::ST_POP_D: begin
				state_d = ntm_pkg::ST_FINISH;
			end
			ntm_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ntm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ntm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ntm_pkg::ST_IDLE;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`NTM_ASSERT_IMPL(a_rem_live, (state_q == ntm_pkg::ST_SCAN) || (state_q == ntm_pkg::ST_POP), rem_q != '0, "sweep state with nothing left to read")
	`NTM_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(state_q == ntm_pkg::ST_FINISH), "result raised outside finish")

endmodule

@@ design/nearest_timestamp_matcher.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nearest_timestamp_matcher
// Ring of (source, host) stamp pairs with nearest-source lookup and pop.
// -----------------------------------------------------------------------------
// A record request appends a pair, dropping the oldest pair when the ring
// already holds DEPTH pairs. For a lookup with n pairs stored, the single read
// port of the pair memory is swept once over all n entries to find the nearest
// source stamp (oldest wins a tie), then swept again from the head to pop every
// front entry whose source stamp is at most the best one. A lookup on an empty
// ring answers with current_time and was_found low. Each lookup gives one
// result, a record gives none. latency_ns is to be written through cfg_we only
// while the block is idle (the block itself does not enforce this), and it is
// subtracted (wrapping) from the matched host stamp.
// -----------------------------------------------------------------------------
module nearest_timestamp_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic signed [ntm_pkg::KW-1:0] source_stamp,
	input  logic signed [ntm_pkg::KW-1:0] host_stamp,
	input  logic signed [ntm_pkg::KW-1:0] current_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [ntm_pkg::KW-1:0] matched_stamp,
	output logic                          was_found,
	input  logic                          cfg_we,
	input  logic signed [ntm_pkg::LW-1:0] latency_ns
);

	ntm_pkg::cmd_t    cmd;
	ntm_pkg::status_t status;

	ntm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ntm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.source_stamp (source_stamp),
		.host_stamp   (host_stamp),
		.current_time (current_time),
		.cfg_we       (cfg_we),
		.latency_ns   (latency_ns),
		.status       (status),
		.matched_stamp(matched_stamp),
		.was_found    (was_found)
	);

endmodule

@@ bench/stamp_match_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stamp_match_checker
// Watches the request, result and latency ports of the matcher. It keeps its
// own ring of stamp pairs, predicts the answer of every lookup and compares
// each result with the oldest prediction.
// -----------------------------------------------------------------------------
module stamp_match_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          opcode,
	input  logic signed [ntm_pkg::KW-1:0] source_stamp,
	input  logic signed [ntm_pkg::KW-1:0] host_stamp,
	input  logic signed [ntm_pkg::KW-1:0] current_time,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [ntm_pkg::KW-1:0] matched_stamp,
	input  logic                          was_found,
	input  logic                          cfg_we,
	input  logic signed [ntm_pkg::LW-1:0] latency_ns,
	output int                            mismatches,
	output int                            pending
);

	typedef struct {
		logic signed [ntm_pkg::KW-1:0] src;
		logic signed [ntm_pkg::KW-1:0] host;
	} stamp_pair_t;

	typedef struct {
		logic signed [ntm_pkg::KW-1:0] stamp;
		logic                          found;
	} match_t;

	stamp_pair_t                   stamp_pairs [$];
	match_t                        answers_due [$];
	logic signed [ntm_pkg::LW-1:0] lat_now;

	task automatic note_mismatch(input string what, input logic [ntm_pkg::KW-1:0] want, got);
		if (mismatches < 10) begin
			$display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [ntm_pkg::KW:0]   qx, kx;
		logic [ntm_pkg::KW:0]          gap, best_gap;
		logic signed [ntm_pkg::KW-1:0] best_key, lat64;
		int                            best, i;
		match_t                        want;
		stamp_pair_t                   pair;
		if (!arst_n) begin
			stamp_pairs.delete();
			answers_due.delete();
			lat_now    = '0;
			mismatches = 0;
			pending    = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					note_mismatch("result with no lookup waiting", '0, matched_stamp);
				end else begin
					want = answers_due[0];
					answers_due.delete(0);
					if (matched_stamp !== want.stamp) begin
						note_mismatch("matched_stamp", want.stamp, matched_stamp);
					end
					if (was_found !== want.found) begin
						note_mismatch("was_found", ntm_pkg::KW'(want.found),
							ntm_pkg::KW'(was_found));
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (opcode == ntm_pkg::OP_RECORD) begin
					// full ring: oldest pair goes first
					if (stamp_pairs.size() == ntm_pkg::DEPTH) begin
						stamp_pairs.delete(0);
					end
					pair.src  = source_stamp;
					pair.host = host_stamp;
					stamp_pairs.insert(stamp_pairs.size(), pair);
				end else if (stamp_pairs.size() == 0) begin
					want.stamp = current_time;
					want.found = 1'b0;
					answers_due.insert(answers_due.size(), want);
				end else begin
					// 65-bit distances; strict less-than keeps the oldest on a tie
					qx       = (ntm_pkg::KW+1)'(source_stamp);
					kx       = (ntm_pkg::KW+1)'(stamp_pairs[0].src);
					best_gap = (kx >= qx) ? kx - qx : qx - kx;
					best     = 0;
					for (i = 1; i < stamp_pairs.size(); i++) begin
						kx  = (ntm_pkg::KW+1)'(stamp_pairs[i].src);
						gap = (kx >= qx) ? kx - qx : qx - kx;
						if (gap < best_gap) begin
							best_gap = gap;
							best     = i;
						end
					end
					best_key   = stamp_pairs[best].src;
					lat64      = ntm_pkg::KW'(lat_now);
					want.stamp = stamp_pairs[best].host - lat64;
					want.found = 1'b1;
					answers_due.insert(answers_due.size(), want);
					// pop stops at the first front key above the best key
					while (stamp_pairs.size() > 0 && stamp_pairs[0].src <= best_key) begin
						stamp_pairs.delete(0);
					end
				end
			end
			if (cfg_we) begin
				lat_now = latency_ns;
			end
			pending = answers_due.size();
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the nearest timestamp matcher. Directed corner
// requests, then timestamp streams mixed with noise under several latency
// settings, then a fill past the ring depth. Both sides idle at random.
// -----------------------------------------------------------------------------
module tb;

	localparam int unsigned        LIMIT  = 2_500_000;
	localparam int                 SETTLE = 16;
	localparam logic signed [63:0] S_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S_MIN  = 64'sh8000_0000_0000_0000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          opcode;
	logic signed [ntm_pkg::KW-1:0] source_stamp;
	logic signed [ntm_pkg::KW-1:0] host_stamp;
	logic signed [ntm_pkg::KW-1:0] current_time;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [ntm_pkg::KW-1:0] matched_stamp;
	logic                          was_found;
	logic                          cfg_we;
	logic signed [ntm_pkg::LW-1:0] latency_ns;

	int          mismatches;
	int          pending;
	int          sent = 0;
	logic        calm = 1'b0;
	int unsigned cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	nearest_timestamp_matcher DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.source_stamp (source_stamp),
		.host_stamp   (host_stamp),
		.current_time (current_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.matched_stamp(matched_stamp),
		.was_found    (was_found),
		.cfg_we       (cfg_we),
		.latency_ns   (latency_ns)
	);

	stamp_match_checker u_stamp_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.source_stamp (source_stamp),
		.host_stamp   (host_stamp),
		.current_time (current_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.matched_stamp(matched_stamp),
		.was_found    (was_found),
		.cfg_we       (cfg_we),
		.latency_ns   (latency_ns),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 32);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [63:0] edge_value();
		logic signed [63:0] v;
		case ($urandom_range(0, 7))
			0: v = S_MIN;
			1: v = S_MAX;
			2: v = 64'sd0;
			3: v = -64'sd1;
			4: v = 64'sd1;
			5: v = S_MIN + 64'sd1;
			6: v = S_MAX - 64'sd1;
			default: v = rand64();
		endcase
		return v;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input logic op, input logic [63:0] src, host, cur);
		while (!calm && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		source_stamp <= src;
		host_stamp   <= host;
		current_time <= cur;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic record_pair(input logic [63:0] src, host);
		send_req(ntm_pkg::OP_RECORD, src, host, rand64());
	endtask

	task automatic lookup_at(input logic [63:0] query, cur);
		send_req(ntm_pkg::OP_LOOKUP, query, rand64(), cur);
	endtask

	// sender holds off until every lookup has answered and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_latency(input logic signed [ntm_pkg::LW-1:0] v);
		settle();
		cfg_we     <= 1'b1;
		latency_ns <= v;
		@(negedge clk);
		cfg_we     <= 1'b0;
	endtask

	initial begin
		logic signed [63:0]            base, step, host_off, key, query;
		logic signed [63:0]            ep_keys [8];
		logic signed [ntm_pkg::LW-1:0] lat_plan [4];
		int                            chunk, target, kind, n, i;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = ntm_pkg::OP_RECORD;
		source_stamp = '0;
		host_stamp   = '0;
		current_time = '0;
		cfg_we       = 1'b0;
		latency_ns   = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty ring falls back to current_time
		lookup_at(rand64(), S_MAX);
		lookup_at(rand64(), S_MIN);
		// extreme keys: distance from zero is 2^63 vs 2^63-1
		record_pair(S_MIN, S_MAX);
		record_pair(S_MAX, S_MIN);
		lookup_at(64'sd0, rand64());
		// tie goes to the oldest
		record_pair(-64'sd1, 64'h5555_5555_5555_5555);
		record_pair(64'sd1, 64'hAAAA_AAAA_AAAA_AAAA);
		lookup_at(64'sd0, rand64());
		lookup_at(S_MAX, rand64());
		// pop stops at a larger front key while the best entry stays
		record_pair(64'sd10, rand64());
		record_pair(64'sd30, rand64());
		record_pair(64'sd20, rand64());
		lookup_at(64'sd21, rand64());
		lookup_at(64'sd20, rand64());
		lookup_at(S_MAX, rand64());
		// full 64-bit distance
		record_pair(S_MAX, 64'sd0);
		record_pair(64'sd0, -64'sd1);
		lookup_at(S_MIN, rand64());
		lookup_at(S_MAX, rand64());

		lat_plan[0] = 41'sh0FF_FFFF_FFFF;
		lat_plan[1] = 41'sh100_0000_0000;
		lat_plan[2] = -41'sd1;
		lat_plan[3] = ntm_pkg::LW'(rand64());
		base     = rand64();
		step     = 64'sd1000;
		host_off = rand64();
		for (chunk = 0; chunk < 4; chunk++) begin
			write_latency(lat_plan[chunk]);
			calm   = (chunk == 1);
			target = sent + 6;
			while (sent < target) begin
				kind = $urandom_range(0, 99);
				if (kind < 65) begin
					// a stream of increasing stamps, then one lookup near it
					n = $urandom_range(1, 8);
					if ($urandom_range(0, 3) == 0) begin
						base     = edge_value();
						host_off = rand64();
					end else begin
						base = base + step * 64'sd9;
					end
					step = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 2))
						: 64'($urandom_range(1, 100000));
					for (i = 0; i < n; i++) begin
						key = base + step * 64'(i) + 64'($urandom_range(0, 1));
						record_pair(key, key + host_off + 64'($urandom_range(0, 5000)));
						ep_keys[i] = key;
					end
					key = ep_keys[$urandom_range(0, n - 1)];
					case ($urandom_range(0, 3))
						0: query = key;
						1: query = key + step / 64'sd2;
						2: query = ep_keys[n - 1] + 64'($urandom);
						default: query = rand64();
					endcase
					lookup_at(query, rand64());
				end else if (kind < 85) begin
					if ($urandom_range(0, 1) == 0) begin
						record_pair(edge_value(), rand64());
					end else begin
						lookup_at(edge_value(), rand64());
					end
				end else begin
					// out of order stamps or back to back lookups
					n = $urandom_range(0, 4);
					for (i = 0; i < n; i++) begin
						record_pair(base - step * 64'(i), rand64());
					end
					lookup_at(base + 64'($urandom_range(0, 200000)) - 64'sd100000, rand64());
					lookup_at(rand64(), rand64());
				end
			end
		end

		// fill past the depth so the oldest pairs drop
		write_latency(ntm_pkg::LW'(rand64()));
		lookup_at(S_MAX, rand64());
		base = $signed(rand64()) >>> 3;
		step = 64'($urandom_range(1, 1000));
		for (i = 0; i < ntm_pkg::DEPTH + 16; i++) begin
			calm = (i < 300);
			record_pair(base + step * 64'(i), rand64());
			if (i % 128 == 127 || i == ntm_pkg::DEPTH + 8) begin
				lookup_at(base - 64'sd1, rand64());
			end
		end
		calm = 1'b0;
		lookup_at(base + step * 64'($urandom_range(0, ntm_pkg::DEPTH + 15)), rand64());
		lookup_at(S_MAX, rand64());

		settle();
		repeat (32) @(negedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
